@@ sv/madt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_pkg
// Shared types, codes and sizes for the MADT table parser.
// ----------------------------------------------------------------------------
package madt_pkg;

  // sizes
  localparam int ISA_SLOTS    = 16;
  localparam int IOAPIC_SLOTS = 8;
  localparam int ENTRY_BYTES  = 16;
  localparam int ISA_W        = (ISA_SLOTS > 1) ? $clog2(ISA_SLOTS) : 1;
  localparam int EB_W         = $clog2(ENTRY_BYTES);

  // result queue
  localparam int RES_DEPTH = 8;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_LVL_W = RES_PTR_W + 1;

  // table layout
  localparam logic [31:0] HDR_BYTES    = 32'd44;
  localparam logic [31:0] MIN_TBL_LEN  = 32'd36;
  localparam logic [32:0] MIN_USED     = 33'd8;
  localparam logic [31:0] SIG_END      = 32'd4;
  localparam logic [31:0] LEN_END      = 32'd8;
  localparam logic [31:0] LAPIC_START  = 32'd36;
  localparam logic [31:0] LAPIC_END    = 32'd40;
  localparam logic [31:0] SIGNATURE    = 32'h4349_5041;  // "APIC", byte 0 lowest

  // input commands
  localparam logic [1:0] CMD_NEXT   = 2'd0;
  localparam logic [1:0] CMD_FIRST  = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_SUMMARY = 2'd0;
  localparam logic [1:0] KIND_IOAPIC  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  // entry types
  localparam logic [7:0] ENT_LAPIC     = 8'd0;
  localparam logic [7:0] ENT_IOAPIC    = 8'd1;
  localparam logic [7:0] ENT_ISO       = 8'd2;
  localparam logic [7:0] ENT_LAPIC_OVR = 8'd5;
  localparam logic [7:0] ENT_X2APIC    = 8'd9;

  typedef struct packed {
    logic        last_of_run;
    logic [1:0]  result_kind;
    logic        stopped_early;
    logic        table_valid;
    logic [31:0] gsi;
    logic [31:0] ioapic_gsi_base;
    logic [31:0] ioapic_address;
    logic [7:0]  ioapic_tag;
    logic [63:0] lapic_base;
    logic [15:0] override_count;
    logic [3:0]  ioapic_total;
    logic [15:0] proc_count;
  } result_t;

  // words produced by one item, in order
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_wr_t;

endpackage

@@ sv/madt_parse.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_parse
// Input register, table state and per-byte parse; emits up to two result words.
// ----------------------------------------------------------------------------
module madt_parse (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_take,
  input  logic [1:0]       in_cmd,
  input  logic [7:0]       in_byte,
  input  logic [7:0]       in_irq,
  output logic             pend,
  output madt_pkg::res_wr_t wr
);
  import madt_pkg::*;

  // input register
  logic        in_valid;
  logic [1:0]  cmd_q;
  logic [7:0]  byte_q;
  logic [7:0]  irq_q;

  // table state
  logic [31:0] byte_offset;
  logic [31:0] declared_length;
  logic [7:0]  running_sum;
  logic        signature_good;
  logic [63:0] lapic_base_reg;
  logic [7:0]  entry_buffer [ENTRY_BYTES];
  logic [7:0]  entry_position;
  logic        walk_stopped;
  logic [15:0] proc_counter;
  logic [15:0] override_counter;
  logic [3:0]  ioapic_stored;
  logic [31:0] gsi_map [ISA_SLOTS];
  logic        table_present;
  logic        summary_sent;

  // state after a restart is applied
  logic        restart, take, lookup;
  logic [31:0] off_e, dl_e;
  logic [7:0]  sum_e, pos_e;
  logic        sig_e, stop_e;
  logic [63:0] lapic_e;
  logic [15:0] cpu_e, ovr_e;
  logic [3:0]  ioc_e;

  // next state
  logic [31:0] byte_offset_next, declared_length_next;
  logic [7:0]  running_sum_next, entry_position_next;
  logic        signature_good_next, walk_stopped_next;
  logic [63:0] lapic_base_reg_next;
  logic [15:0] proc_counter_next, override_counter_next;
  logic [3:0]  ioapic_stored_next;
  logic        table_present_next, summary_sent_next;

  logic             buf_we;
  logic [EB_W-1:0]  buf_idx;
  logic [7:0]       v [12];
  logic             finish;
  logic [7:0]       ent_len;
  logic             map_we;
  logic [ISA_W-1:0] map_idx;
  logic [31:0]      map_val;
  logic [32:0]      used, off_p2, ent_end;
  logic [31:0]      start;
  logic             rec_v, sum_v;
  logic [31:0]      lkp_gsi;
  result_t          r_rec, r_sum, r_lkp;

  assign pend = in_valid;

  always_comb begin
    restart = in_valid && (cmd_q == CMD_FIRST);
    take    = in_valid && (restart ||
              ((cmd_q == CMD_NEXT) && table_present && !summary_sent));
    lookup  = in_valid && (cmd_q == CMD_LOOKUP);

    off_e   = restart ? '0 : byte_offset;
    dl_e    = restart ? '0 : declared_length;
    sum_e   = restart ? '0 : running_sum;
    sig_e   = restart ? 1'b1 : signature_good;
    lapic_e = restart ? '0 : lapic_base_reg;
    pos_e   = restart ? '0 : entry_position;
    stop_e  = restart ? 1'b0 : walk_stopped;
    cpu_e   = restart ? '0 : proc_counter;
    ovr_e   = restart ? '0 : override_counter;
    ioc_e   = restart ? '0 : ioapic_stored;

    byte_offset_next      = off_e;
    declared_length_next  = dl_e;
    running_sum_next      = sum_e;
    signature_good_next   = sig_e;
    lapic_base_reg_next   = lapic_e;
    entry_position_next   = pos_e;
    walk_stopped_next     = stop_e;
    proc_counter_next     = cpu_e;
    override_counter_next = ovr_e;
    ioapic_stored_next    = ioc_e;
    table_present_next    = restart ? 1'b1 : table_present;
    summary_sent_next     = restart ? 1'b0 : summary_sent;

    buf_we  = 1'b0;
    buf_idx = pos_e[EB_W-1:0];
    finish  = 1'b0;
    ent_len = entry_buffer[1];
    map_we  = 1'b0;
    map_idx = '0;
    map_val = '0;
    rec_v   = 1'b0;
    sum_v   = 1'b0;
    off_p2  = {1'b0, off_e} + 33'd2;
    start   = off_e - 32'd1;
    ent_end = {1'b0, start} + {25'd0, byte_q};
    used    = {1'b0, off_e} + 33'd1;

    if (take) begin
      running_sum_next = sum_e + byte_q;
      if (off_e < SIG_END) begin
        if (byte_q != SIGNATURE[{off_e[1:0], 3'b000} +: 8]) signature_good_next = 1'b0;
      end else if (off_e < LEN_END) begin
        declared_length_next = dl_e | ({24'd0, byte_q} << {off_e[1:0], 3'b000});
      end else if (off_e >= LAPIC_START && off_e < LAPIC_END) begin
        lapic_base_reg_next = lapic_e | ({56'd0, byte_q} << {off_e[1:0], 3'b000});
      end else if (off_e >= HDR_BYTES && !stop_e && off_e < dl_e) begin
        // a lone trailing byte cannot start an entry
        if (!(pos_e == 8'd0 && off_p2 > {1'b0, dl_e})) begin
          buf_we = (pos_e < 8'(ENTRY_BYTES));
          if (pos_e == 8'd1) begin
            if (byte_q < 8'd2 || ent_end > {1'b0, dl_e}) begin
              walk_stopped_next   = 1'b1;
              entry_position_next = '0;
            end else if (byte_q == 8'd2) begin
              entry_position_next = '0;  // header-only entry has no effect
            end else begin
              entry_position_next = 8'd2;
            end
          end else if (pos_e == 8'd0) begin
            entry_position_next = 8'd1;
          end else if ({1'b0, pos_e} + 9'd1 >= {1'b0, ent_len}) begin
            finish              = 1'b1;
            entry_position_next = '0;
          end else begin
            entry_position_next = pos_e + 8'd1;
          end
        end
      end
    end

    // entry bytes with the byte of this cycle merged in
    for (int i = 0; i < 12; i++) begin
      v[i] = (buf_we && buf_idx == EB_W'(i)) ? byte_q : entry_buffer[i];
    end

    if (finish) begin
      unique case (v[0])
        ENT_LAPIC: begin
          if (ent_len >= 8'd8 && v[4][0] && cpu_e != 16'hFFFF)
            proc_counter_next = cpu_e + 16'd1;
        end
        ENT_IOAPIC: begin
          if (ent_len >= 8'd12 && ioc_e < 4'(IOAPIC_SLOTS)) begin
            ioapic_stored_next = ioc_e + 4'd1;
            rec_v              = 1'b1;
          end
        end
        ENT_ISO: begin
          if (ent_len >= 8'd10) begin
            if ({1'b0, v[3]} < 9'(ISA_SLOTS)) begin
              map_we  = 1'b1;
              map_idx = v[3][ISA_W-1:0];
              map_val = {v[7], v[6], v[5], v[4]};
            end
            if (ovr_e != 16'hFFFF) override_counter_next = ovr_e + 16'd1;
          end
        end
        ENT_LAPIC_OVR: begin
          if (ent_len >= 8'd12)
            lapic_base_reg_next = {v[11], v[10], v[9], v[8], v[7], v[6], v[5], v[4]};
        end
        ENT_X2APIC: begin
          if (ent_len >= 8'd16 && v[8][0] && cpu_e != 16'hFFFF)
            proc_counter_next = cpu_e + 16'd1;
        end
        default: ;
      endcase
    end

    if (take) begin
      byte_offset_next = used[31:0];
      if (used >= MIN_USED && used >= {1'b0, declared_length_next}) begin
        sum_v             = 1'b1;
        summary_sent_next = 1'b1;
      end
    end

    lkp_gsi = ({1'b0, irq_q} < 9'(ISA_SLOTS)) ? gsi_map[irq_q[ISA_W-1:0]]
                                               : {24'd0, irq_q};

    r_rec                 = '0;
    r_rec.result_kind     = KIND_IOAPIC;
    r_rec.ioapic_tag      = v[2];
    r_rec.ioapic_address  = {v[7], v[6], v[5], v[4]};
    r_rec.ioapic_gsi_base = {v[11], v[10], v[9], v[8]};

    r_sum               = '0;
    r_sum.result_kind   = KIND_SUMMARY;
    r_sum.table_valid   = (running_sum_next == 8'd0) && signature_good_next &&
                          (declared_length_next >= MIN_TBL_LEN);
    r_sum.stopped_early = walk_stopped_next;

    r_lkp             = '0;
    r_lkp.result_kind = KIND_LOOKUP;
    r_lkp.gsi         = lkp_gsi;

    // counters and base as they stand after this item
    r_rec.proc_count = proc_counter_next;  r_rec.ioapic_total = ioapic_stored_next;
    r_sum.proc_count = proc_counter_next;  r_sum.ioapic_total = ioapic_stored_next;
    r_lkp.proc_count = proc_counter_next;  r_lkp.ioapic_total = ioapic_stored_next;
    r_rec.override_count = override_counter_next;
    r_sum.override_count = override_counter_next;
    r_lkp.override_count = override_counter_next;
    r_rec.lapic_base = lapic_base_reg_next;
    r_sum.lapic_base = lapic_base_reg_next;
    r_lkp.lapic_base = lapic_base_reg_next;

    wr = '0;
    if (lookup) begin
      wr.cnt = 2'd1;
      wr.r0  = r_lkp;
      wr.r0.last_of_run = 1'b1;
    end else if (rec_v && sum_v) begin
      wr.cnt = 2'd2;
      wr.r0  = r_rec;
      wr.r1  = r_sum;
      wr.r1.last_of_run = 1'b1;
    end else if (rec_v) begin
      wr.cnt = 2'd1;
      wr.r0  = r_rec;
      wr.r0.last_of_run = 1'b1;
    end else if (sum_v) begin
      wr.cnt = 2'd1;
      wr.r0  = r_sum;
      wr.r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q  <= in_cmd;
      byte_q <= in_byte;
      irq_q  <= in_irq;
    end
    if (buf_we) entry_buffer[buf_idx] <= byte_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid         <= 1'b0;
      byte_offset      <= '0;
      declared_length  <= '0;
      running_sum      <= '0;
      signature_good   <= 1'b1;
      lapic_base_reg   <= '0;
      entry_position   <= '0;
      walk_stopped     <= 1'b0;
      proc_counter     <= '0;
      override_counter <= '0;
      ioapic_stored    <= '0;
      table_present    <= 1'b0;
      summary_sent     <= 1'b0;
      for (int i = 0; i < ISA_SLOTS; i++) gsi_map[i] <= 32'(i);
    end else begin
      in_valid         <= in_take;
      byte_offset      <= byte_offset_next;
      declared_length  <= declared_length_next;
      running_sum      <= running_sum_next;
      signature_good   <= signature_good_next;
      lapic_base_reg   <= lapic_base_reg_next;
      entry_position   <= entry_position_next;
      walk_stopped     <= walk_stopped_next;
      proc_counter     <= proc_counter_next;
      override_counter <= override_counter_next;
      ioapic_stored    <= ioapic_stored_next;
      table_present    <= table_present_next;
      summary_sent     <= summary_sent_next;
      if (restart) begin
        for (int i = 0; i < ISA_SLOTS; i++) gsi_map[i] <= 32'(i);
      end else if (map_we) begin
        gsi_map[map_idx] <= map_val;
      end
    end
  end

endmodule

@@ sv/madt_result_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_result_fifo
// Result word queue: takes up to two words a cycle, gives one while the receiver is ready.
// ----------------------------------------------------------------------------
module madt_result_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  madt_pkg::res_wr_t             wr,
  input  logic                          pop_ready,
  output logic                          out_valid,
  output madt_pkg::result_t             head,
  output logic [madt_pkg::RES_LVL_W-1:0] level
);
  import madt_pkg::*;

  result_t              mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wp, rp;
  logic                 pop;
  logic [RES_LVL_W-1:0] level_next;

  assign out_valid  = (level != '0);
  assign head       = mem[rp];
  assign pop        = out_valid && pop_ready;
  assign level_next = level + RES_LVL_W'(wr.cnt) - RES_LVL_W'(pop);

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) mem[wp] <= wr.r0;
    if (wr.cnt == 2'd2) mem[wp + RES_PTR_W'(1)] <= wr.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      wp    <= wp + RES_PTR_W'(wr.cnt);
      rp    <= rp + RES_PTR_W'(pop);
      level <= level_next;
    end
  end

endmodule

@@ sv/madt_table_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_table_parser_core
// Streaming MADT parser: byte-wise table walk, I/O APIC records, IRQ lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one word per accepted handshake: tuser is the command
//   (next byte, first byte / restart, GSI lookup), tdata carries the table
//   byte and the ISA IRQ. Master side gives result words: tuser is the kind
//   (summary, I/O APIC record, lookup answer), tlast marks the final word
//   caused by one input word. One input word yields zero, one or two words
//   (an I/O APIC record followed by the table summary on the last byte).
// Path: a word accepted on the slave side sits in the input register, is
//   parsed in one pass and lands in the result queue; tvalid is high right
//   after that write.
// Throughput: one input word per cycle while the queue has room. The limit
//   is the eight-word result queue: tready drops while the queue level plus
//   the words still owed by the input register leaves no room for two more.
// Stall: a stalled receiver only fills the queue; no word is lost or
//   repeated, and intake resumes as the queue drains.
// Reset: clears all table state, loads the identity IRQ-to-GSI map and
//   empties the queue; there is no clearing pass. tready is held low while
//   rst is high.
// ----------------------------------------------------------------------------
module madt_table_parser_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,   // [7:0] data_byte, [15:8] isa_irq
  input  logic [1:0]    s_axis_tuser,   // [1:0] command
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [15:0] proc_count, [19:16] ioapic_total, [35:20] override_count,
  // [99:36] lapic_base, [107:100] ioapic_tag, [139:108] ioapic_address,
  // [171:140] ioapic_gsi_base, [203:172] gsi, [204] table_valid,
  // [205] stopped_early, [207:206] zero
  output logic [207:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser,   // [1:0] result_kind
  output logic          m_axis_tlast    // last_of_run
);
  import madt_pkg::*;

  logic                 in_take;
  logic                 pend;
  res_wr_t              wr;
  result_t              head;
  logic [RES_LVL_W-1:0] level;
  logic [RES_LVL_W:0]   committed;

  // words in the queue plus worst case still owed by the input register
  assign committed     = {1'b0, level} + (pend ? (RES_LVL_W+1)'(2) : '0);
  assign s_axis_tready = !rst && (committed <= (RES_LVL_W+1)'(RES_DEPTH - 2));
  assign in_take       = s_axis_tvalid && s_axis_tready;

  madt_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .in_take (in_take),
    .in_cmd  (s_axis_tuser),
    .in_byte (s_axis_tdata[7:0]),
    .in_irq  (s_axis_tdata[15:8]),
    .pend    (pend),
    .wr      (wr)
  );

  madt_result_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .pop_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .head      (head),
    .level     (level)
  );

  assign m_axis_tdata = {2'b00, head.stopped_early, head.table_valid, head.gsi,
                         head.ioapic_gsi_base, head.ioapic_address, head.ioapic_tag,
                         head.lapic_base, head.override_count, head.ioapic_total,
                         head.proc_count};
  assign m_axis_tuser = head.result_kind;
  assign m_axis_tlast = head.last_of_run;

endmodule

@@ tb/madt_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madt_result_checker
// Watches both streams of the MADT parser, predicts every result word from
// the accepted input words and compares each result word against it.
// ----------------------------------------------------------------------------
module madt_result_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,   // [7:0] data_byte, [15:8] isa_irq
  input  logic [1:0]   s_axis_tuser,   // [1:0] command
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [207:0] m_axis_tdata,   // counters, base, record, gsi, flags
  input  logic [1:0]   m_axis_tuser,   // [1:0] result_kind
  input  logic         m_axis_tlast,   // last_of_run
  output int           mismatches,
  output int           words_owed
);
  import madt_pkg::*;

  localparam int REPORT_MAX = 10;

  result_t     owed_q [$];

  // parser state as the block should hold it
  logic [31:0] byte_off;
  logic [31:0] decl_len;
  logic [7:0]  cksum;
  logic        sig_ok;
  logic [63:0] lapic_base;
  logic [7:0]  ent_buf [ENTRY_BYTES];
  int          ent_pos;
  logic        walk_halt;
  logic [15:0] cpus;
  logic [15:0] overrides;
  logic [3:0]  ioapics;
  logic [31:0] irq_map [ISA_SLOTS];
  logic        parsing;
  logic        summary_done;

  int          step_words;
  int          err_cnt  = 0;
  int          word_cnt = 0;

  task automatic clear_parse();
    int i;
    byte_off     = '0;
    decl_len     = '0;
    cksum        = '0;
    sig_ok       = 1'b1;
    lapic_base   = '0;
    ent_pos      = 0;
    walk_halt    = 1'b0;
    cpus         = '0;
    overrides    = '0;
    ioapics      = '0;
    parsing      = 1'b0;
    summary_done = 1'b0;
    for (i = 0; i < ENTRY_BYTES; i++) ent_buf[i] = '0;
    for (i = 0; i < ISA_SLOTS; i++) irq_map[i] = i;
  endtask

  // little-endian field out of the buffered entry
  function automatic logic [63:0] ent_le(input int at, input int n);
    logic [63:0] v;
    int          i;
    v = '0;
    for (i = 0; i < n; i++) v = v | (64'(ent_buf[at + i]) << (8 * i));
    return v;
  endfunction

  task automatic post_word(input logic [1:0] kind, input logic [7:0] id,
                           input logic [31:0] addr, input logic [31:0] gbase,
                           input logic [31:0] g, input logic valid,
                           input logic stopped);
    result_t w;
    w                 = '0;
    w.result_kind     = kind;
    w.proc_count      = cpus;
    w.ioapic_total    = ioapics;
    w.override_count  = overrides;
    w.lapic_base      = lapic_base;
    w.ioapic_tag      = id;
    w.ioapic_address  = addr;
    w.ioapic_gsi_base = gbase;
    w.gsi             = g;
    w.table_valid     = valid;
    w.stopped_early   = stopped;
    owed_q.push_back(w);
    step_words++;
  endtask

  task automatic close_entry(input int len);
    case (ent_buf[0])
      ENT_LAPIC: begin
        if (len >= 8 && ent_buf[4][0] && cpus != 16'hFFFF) cpus++;
      end
      ENT_IOAPIC: begin
        if (len >= 12 && ioapics < IOAPIC_SLOTS) begin
          ioapics++;
          post_word(KIND_IOAPIC, ent_buf[2], 32'(ent_le(4, 4)), 32'(ent_le(8, 4)),
                    '0, 1'b0, 1'b0);
        end
      end
      ENT_ISO: begin
        if (len >= 10) begin
          if (ent_buf[3] < ISA_SLOTS) irq_map[ent_buf[3][ISA_W-1:0]] = 32'(ent_le(4, 4));
          if (overrides != 16'hFFFF) overrides++;
        end
      end
      ENT_LAPIC_OVR: begin
        if (len >= 12) lapic_base = ent_le(4, 8);
      end
      ENT_X2APIC: begin
        if (len >= 16 && ent_buf[8][0] && cpus != 16'hFFFF) cpus++;
      end
      default: ;
    endcase
  endtask

  task automatic parse_byte(input logic [7:0] b);
    logic [32:0] used;
    int          pos;
    cksum = cksum + b;
    if (byte_off < SIG_END) begin
      if (b != SIGNATURE[8 * byte_off[1:0] +: 8]) sig_ok = 1'b0;
    end else if (byte_off < LEN_END) begin
      decl_len = decl_len | (32'(b) << (8 * (byte_off - SIG_END)));
    end else if (byte_off >= LAPIC_START && byte_off < LAPIC_END) begin
      lapic_base = lapic_base | (64'(b) << (8 * (byte_off - LAPIC_START)));
    end else if (byte_off >= HDR_BYTES && !walk_halt && byte_off < decl_len) begin
      pos = ent_pos;
      // a lone trailing byte cannot hold an entry header
      if (!(pos == 0 && {1'b0, byte_off} + 33'd2 > {1'b0, decl_len})) begin
        if (pos < ENTRY_BYTES) ent_buf[pos] = b;
        if (pos == 1) begin
          if (b < 8'd2 || {1'b0, byte_off} - 33'd1 + {25'd0, b} > {1'b0, decl_len}) begin
            walk_halt = 1'b1;
            ent_pos   = 0;
          end else if (b == 8'd2) begin
            close_entry(2);
            ent_pos = 0;
          end else begin
            ent_pos = 2;
          end
        end else if (pos == 0) begin
          ent_pos = 1;
        end else if (pos + 1 >= int'(ent_buf[1])) begin
          close_entry(int'(ent_buf[1]));
          ent_pos = 0;
        end else begin
          ent_pos = pos + 1;
        end
      end
    end
    used = {1'b0, byte_off} + 33'd1;
    if (used >= MIN_USED && used >= {1'b0, decl_len}) begin
      post_word(KIND_SUMMARY, '0, '0, '0, '0,
                cksum == 8'd0 && sig_ok && decl_len >= MIN_TBL_LEN, walk_halt);
      summary_done = 1'b1;
    end
    byte_off = used[31:0];
  endtask

  task automatic predict_word(input logic [1:0] cmd, input logic [7:0] b,
                              input logic [7:0] irq);
    logic [31:0] g;
    result_t     w;
    step_words = 0;
    case (cmd)
      CMD_FIRST: begin
        clear_parse();
        parsing = 1'b1;
        parse_byte(b);
      end
      CMD_NEXT: begin
        if (parsing && !summary_done) parse_byte(b);
      end
      CMD_LOOKUP: begin
        g = {24'd0, irq};
        if (parsing && irq < ISA_SLOTS) g = irq_map[irq[ISA_W-1:0]];
        post_word(KIND_LOOKUP, '0, '0, '0, g, 1'b0, 1'b0);
      end
      default: ;
    endcase
    if (step_words > 0) begin
      w = owed_q.pop_back();
      w.last_of_run = 1'b1;
      owed_q.push_back(w);
    end
  endtask

  function automatic string word_text(input result_t w);
    return $sformatf({"kind=%0d cpu=%0d ioa=%0d ovr=%0d lapic=%h id=%h addr=%h",
                      " gbase=%h gsi=%h valid=%b stop=%b last=%b"},
                     w.result_kind, w.proc_count, w.ioapic_total, w.override_count,
                     w.lapic_base, w.ioapic_tag, w.ioapic_address, w.ioapic_gsi_base,
                     w.gsi, w.table_valid, w.stopped_early, w.last_of_run);
  endfunction

  task automatic check_word();
    result_t got;
    result_t want;
    got                 = '0;
    got.proc_count      = m_axis_tdata[15:0];
    got.ioapic_total    = m_axis_tdata[19:16];
    got.override_count  = m_axis_tdata[35:20];
    got.lapic_base      = m_axis_tdata[99:36];
    got.ioapic_tag      = m_axis_tdata[107:100];
    got.ioapic_address  = m_axis_tdata[139:108];
    got.ioapic_gsi_base = m_axis_tdata[171:140];
    got.gsi             = m_axis_tdata[203:172];
    got.table_valid     = m_axis_tdata[204];
    got.stopped_early   = m_axis_tdata[205];
    got.result_kind     = m_axis_tuser;
    got.last_of_run     = m_axis_tlast;
    word_cnt++;
    if (owed_q.size() == 0) begin
      err_cnt++;
      if (err_cnt <= REPORT_MAX)
        $display("result word %0d not expected: %s", word_cnt, word_text(got));
    end else begin
      want = owed_q.pop_front();
      if (got !== want || m_axis_tdata[207:206] !== 2'b00) begin
        err_cnt++;
        if (err_cnt <= REPORT_MAX) begin
          $display("result word %0d mismatch (pad %b)", word_cnt, m_axis_tdata[207:206]);
          $display("  exp %s", word_text(want));
          $display("  got %s", word_text(got));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      owed_q.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word();
      if (s_axis_tvalid && s_axis_tready)
        predict_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
    end
    mismatches <= err_cnt;
    words_owed <= owed_q.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives whole MADT tables, broken and short tables, restarts and IRQ lookups
// into the parser under bursty input and a stalling receiver; the checker
// beside the block predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import madt_pkg::*;

  localparam logic [1:0] CMD_UNUSED   = 2'd3;  // block must ignore it
  localparam int         ITEMS_TARGET = 550;
  localparam int         IDLE_LIMIT   = 1000;  // gaps and stalls stay far below it
  localparam int         DRAIN_CYCLES = 16;

  // receiver behavior, picked anew at random whenever the current mode runs out
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BURSTY} rx_mode_e;

  logic         clk           = 1'b0;
  logic         rst           = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [15:0]  s_axis_tdata  = '0;   // [7:0] data_byte, [15:8] isa_irq
  logic [1:0]   s_axis_tuser  = CMD_NEXT;  // [1:0] command
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [207:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  int           mismatches;
  int           words_owed;

  logic [7:0]   tbl [$];        // bytes of the table being sent
  int           burst_left = 0;
  int           n_items    = 0;

  rx_mode_e     rx_mode       = RX_OPEN;
  int           rx_mode_left  = 0;
  int           rx_stall_left = 0;
  int           rx_tick       = 0;
  int           idle_cycles   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  madt_table_parser_core u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  madt_result_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .mismatches    (mismatches),
    .words_owed    (words_owed)
  );

  // Receiver: open, coin-flip, one-in-four, or long random stalls.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 3));
      rx_mode_left = $urandom_range(32, 256);
    end
    rx_mode_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: m_axis_tready <= (rx_tick % 4 == 0);
      default: begin
        if (rx_stall_left > 0) begin
          rx_stall_left--;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
          rx_stall_left = $urandom_range(5, 40);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    endcase
  end

  // Watchdog: a run of cycles with no word moving on either side is a hang.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One input word; bursts of random length, each preceded by a random gap
  // (zero at times, so some bursts run back to back).
  task automatic push_word(input logic [1:0] cmd, input logic [7:0] dbyte,
                           input logic [7:0] irq);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {irq, dbyte};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    n_items++;
  endtask

  // mostly inside the map, sometimes anywhere in the byte
  function automatic logic [7:0] pick_irq();
    return ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 17))
                                       : 8'($urandom_range(0, 255));
  endfunction

  // Builds one table into tbl: short header-only tables, abandoned partial
  // tables with random length fields, or full tables with an entry walk and
  // at most one fault.
  task automatic make_table();
    int          flavor;
    int          fault;
    int          n_ent;
    int          e;
    int          k;
    int          s;
    int          sel;
    int          len;
    int          layout;
    int          want;
    logic [7:0]  etype;
    logic [7:0]  sum;
    logic [31:0] decl;
    logic        heavy;
    tbl.delete();
    for (k = 0; k < 44; k++) tbl.push_back(8'($urandom_range(0, 255)));
    for (k = 0; k < 4; k++) tbl[k] = SIGNATURE[8 * k +: 8];
    flavor = $urandom_range(0, 9);
    fault  = $urandom_range(0, 9);
    if (flavor == 0) begin
      // header cut short: no walk, missing fields stay zero
      decl = $urandom_range(0, 43);
    end else if (flavor == 1) begin
      // random length field, only part sent; the next table restarts it
      want = $urandom_range(1, 60);
      while (tbl.size() < want) tbl.push_back(8'($urandom_range(0, 255)));
      while (tbl.size() > want) void'(tbl.pop_back());
      return;
    end else begin
      heavy = ($urandom_range(0, 7) == 0);   // overflows the I/O APIC slots
      n_ent = heavy ? $urandom_range(9, 11) : $urandom_range(0, 6);
      for (e = 0; e < n_ent; e++) begin
        sel = heavy ? 2 : $urandom_range(0, 9);
        case (sel)
          0, 1: begin etype = ENT_LAPIC;     layout = 8;  end
          2, 3: begin etype = ENT_IOAPIC;    layout = 12; end
          4, 5: begin etype = ENT_ISO;       layout = 10; end
          6:    begin etype = ENT_LAPIC_OVR; layout = 12; end
          7:    begin etype = ENT_X2APIC;    layout = 16; end
          default: begin
            etype  = 8'($urandom_range(0, 255));
            layout = $urandom_range(2, 24);
          end
        endcase
        len = layout;
        if (!heavy) begin
          k = $urandom_range(0, 9);
          if (k == 0) len = $urandom_range(2, layout);          // short for its type
          else if (k == 1) len = layout + $urandom_range(1, 14); // longer than its type
        end
        s = tbl.size();
        tbl.push_back(etype);
        tbl.push_back(8'(len));
        for (k = 2; k < len; k++) tbl.push_back(8'($urandom_range(0, 255)));
        if (etype == ENT_ISO && len > 3 && $urandom_range(0, 3) != 0)
          tbl[s + 3] = 8'($urandom_range(0, ISA_SLOTS - 1));
      end
      if (fault == 0) begin
        // entry length below two stops the walk
        tbl.push_back(8'($urandom_range(0, 255)));
        tbl.push_back(8'($urandom_range(0, 1)));
        k = $urandom_range(3, 10);
        repeat (k) tbl.push_back(8'($urandom_range(0, 255)));
      end else if (fault == 2) begin
        // lone trailing byte
        tbl.push_back(8'($urandom_range(0, 255)));
      end
      decl = tbl.size();
      if (fault == 1) decl = decl - $urandom_range(1, 4);  // last entry overruns
    end
    if (fault == 3) tbl[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
    for (k = 0; k < 4; k++) tbl[4 + k] = decl[8 * k +: 8];
    want = (decl < 8) ? 8 : decl;
    while (tbl.size() > want) void'(tbl.pop_back());
    if (fault != 4 && tbl.size() > 8) begin
      sum = '0;
      for (k = 0; k < tbl.size(); k++) sum = sum + tbl[k];
      s = (tbl.size() > 9) ? 9 : 8;
      tbl[s] = tbl[s] - sum;
    end
  endtask

  // Sends tbl; with extras, lookups and unknown commands are mixed in, and
  // stray bytes and lookups follow the table.
  task automatic send_table(input logic extras);
    int k;
    int n;
    for (k = 0; k < tbl.size(); k++) begin
      if (extras && $urandom_range(0, 11) == 0)
        push_word(CMD_LOOKUP, 8'($urandom_range(0, 255)), pick_irq());
      if (extras && $urandom_range(0, 39) == 0)
        push_word(CMD_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      push_word((k == 0) ? CMD_FIRST : CMD_NEXT, tbl[k], 8'($urandom_range(0, 255)));
    end
    if (extras) begin
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) push_word(CMD_NEXT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
      n = $urandom_range(1, 4);
      repeat (n) push_word(CMD_LOOKUP, 8'($urandom_range(0, 255)), pick_irq());
    end
  endtask

  // Directed opening: lookups before any table, bytes with no parse, the
  // unknown command, the smallest table, a byte after the summary, lookups
  // at the map edge, and a zero-length table with a bad signature.
  task automatic run_directed();
    int k;
    push_word(CMD_LOOKUP, 8'h00, 8'h00);
    push_word(CMD_LOOKUP, 8'hFF, 8'hFF);
    push_word(CMD_NEXT, 8'hFF, 8'hFF);
    push_word(CMD_UNUSED, 8'hFF, 8'hFF);
    tbl.delete();
    for (k = 0; k < 4; k++) tbl.push_back(SIGNATURE[8 * k +: 8]);
    tbl.push_back(8'd8);
    repeat (3) tbl.push_back(8'h00);
    send_table(1'b0);
    push_word(CMD_NEXT, 8'h00, 8'h00);
    push_word(CMD_LOOKUP, 8'h00, 8'(ISA_SLOTS - 1));
    push_word(CMD_LOOKUP, 8'hFF, 8'(ISA_SLOTS));
    tbl.delete();
    tbl.push_back(8'h00);
    repeat (3) tbl.push_back(8'hFF);
    repeat (4) tbl.push_back(8'h00);
    send_table(1'b0);
    push_word(CMD_LOOKUP, 8'h00, 8'h80);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    while (n_items < ITEMS_TARGET) begin
      make_table();
      send_table(1'b1);
    end
    s_axis_tvalid <= 1'b0;
    // let the checker see the last word, then drain what is still owed
    repeat (2) @(posedge clk);
    while (words_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && words_owed == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ madt_table_parser_core.f @@
sv/madt_pkg.sv
sv/madt_parse.sv
sv/madt_result_fifo.sv
sv/madt_table_parser_core.sv
tb/madt_result_checker.sv
tb/tb_top.sv
